// ----- sv/l2s_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// l2s_pkg
// Shared widths, types and the threshold tables for the linear-to-sRGB
// encoder. The power table is built at elaboration from the fixed-point
// log2 form of the transfer curve, the linear table by integer division.
// ----------------------------------------------------------------------------
package l2s_pkg;

    localparam int FRAC_BITS = 16;
    localparam int LOG_FRAC  = 40;
    localparam int IN_W      = 20;
    localparam int MAG_W     = IN_W - 1;
    localparam int THR_W     = IN_W;
    localparam int CODE_W    = 8;
    localparam int LANES     = 4;
    localparam int ALPHA_LANE = 3;
    localparam int TBL_N     = 1 << CODE_W;
    localparam int S_DATA_W  = LANES * IN_W;
    localparam int M_DATA_W  = LANES * CODE_W;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    localparam logic REG_ALPHA_ENABLE = 1'b0;

    localparam longint unsigned SENTINEL = 64'd1 << MAG_W;
    localparam longint unsigned LIN_BOUND_W =
        ((64'd31308 << FRAC_BITS) + 64'd9999999) / 64'd10000000;
    localparam logic [MAG_W-1:0] LIN_BOUND = MAG_W'(LIN_BOUND_W);

    typedef logic [TBL_N-1:0][THR_W-1:0] thr_table_t;
    typedef logic [LANES-1:0][CODE_W-1:0] codes_t;

    typedef struct packed {
        logic alpha_enable;
    } cfg_t;

    // (a*b) >> 62 for q62 operands
    function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // log2 of an integer, signed fixed point with LOG_FRAC fraction bits
    function automatic longint log2_fix(logic [63:0] x);
        logic [63:0] xx;
        logic [63:0] t;
        logic [63:0] m;
        logic [63:0] frac;
        int e;
        xx = (x == 64'd0) ? 64'd1 : x;
        t = xx;
        e = 0;
        frac = 64'd0;
        for (int i = 0; i < 62; i++) begin
            if (t > 64'd1 && e < 61) begin
                t = t >> 1;
                e = e + 1;
            end
        end
        m = xx << (62 - e);
        for (int i = 0; i < LOG_FRAC; i++) begin
            m = mul_q62(m, m);
            frac = frac << 1;
            if (m >= 64'h8000_0000_0000_0000) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return (longint'(e) <<< LOG_FRAC) | longint'(frac);
    endfunction

    function automatic logic pow_pred(logic [63:0] n, longint lc);
        longint lf;
        lf = log2_fix(n);
        return (64'sd20833 * (lf - (longint'(FRAC_BITS) <<< LOG_FRAC)))
               >= (64'sd50000 * lc);
    endfunction

    // smallest magnitude giving each code on the power segment
    function automatic thr_table_t build_pow_table();
        thr_table_t tbl;
        longint lq;
        longint lc;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mid;
        tbl = '0;
        lq = log2_fix(64'd53805);
        lo = LIN_BOUND_W;
        for (int k = 1; k < TBL_N; k++) begin
            lc = log2_fix(64'(200 * k + 2705)) - lq;
            hi = SENTINEL;
            for (int i = 0; i <= THR_W; i++) begin
                if (lo < hi) begin
                    mid = (lo + hi) >> 1;
                    if (pow_pred(mid, lc)) begin
                        hi = mid;
                    end else begin
                        lo = mid + 64'd1;
                    end
                end
            end
            tbl[k] = THR_W'(lo);
        end
        return tbl;
    endfunction

    // smallest magnitude giving each code on the linear segment
    function automatic thr_table_t build_lin_table();
        thr_table_t tbl;
        longint unsigned v;
        tbl = '0;
        for (int k = 1; k < TBL_N; k++) begin
            v = ((64'(10 * k - 5) << FRAC_BITS) + 64'd32945) / 64'd32946;
            tbl[k] = (v > SENTINEL) ? THR_W'(SENTINEL) : THR_W'(v);
        end
        return tbl;
    endfunction

    localparam thr_table_t POW_TABLE = build_pow_table();
    localparam thr_table_t LIN_TABLE = build_lin_table();

endpackage
`default_nettype wire

// ----- sv/l2s_lane.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// l2s_lane
// One channel encoder: a pipelined binary search, one code bit per stage,
// against the linear and power threshold tables side by side.
// ----------------------------------------------------------------------------
module l2s_lane (
    input  wire logic                         aclk,
    input  wire logic                         en,
    input  wire logic signed [l2s_pkg::IN_W-1:0] lin_in,
    output logic [l2s_pkg::CODE_W-1:0]        code
);
    import l2s_pkg::*;

    logic [MAG_W-1:0]  mag_reg  [0:CODE_W];
    logic              pos_reg  [0:CODE_W];
    logic              seg_reg  [0:CODE_W];
    logic [CODE_W-1:0] klin_reg [0:CODE_W];
    logic [CODE_W-1:0] kpow_reg [0:CODE_W];

    logic [MAG_W-1:0]  mag_next;
    logic              pos_next;
    logic              seg_next;

    always_comb begin
        mag_next = lin_in[MAG_W-1:0];
        pos_next = !lin_in[IN_W-1] && (lin_in != '0);
        seg_next = mag_next < LIN_BOUND;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg[0]  <= mag_next;
            pos_reg[0]  <= pos_next;
            seg_reg[0]  <= seg_next;
            klin_reg[0] <= '0;
            kpow_reg[0] <= '0;
        end
    end

    for (genvar j = 0; j < CODE_W; j++) begin : g_stage
        localparam logic [CODE_W-1:0] STEP_BIT = CODE_W'(1) << (CODE_W - 1 - j);
        logic [CODE_W-1:0] cand_lin;
        logic [CODE_W-1:0] cand_pow;
        logic [CODE_W-1:0] klin_next;
        logic [CODE_W-1:0] kpow_next;

        always_comb begin
            cand_lin  = klin_reg[j] | STEP_BIT;
            cand_pow  = kpow_reg[j] | STEP_BIT;
            klin_next = ({1'b0, mag_reg[j]} >= LIN_TABLE[cand_lin]) ? cand_lin
                                                                      : klin_reg[j];
            kpow_next = ({1'b0, mag_reg[j]} >= POW_TABLE[cand_pow]) ? cand_pow
                                                                      : kpow_reg[j];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                mag_reg[j+1]  <= mag_reg[j];
                pos_reg[j+1]  <= pos_reg[j];
                seg_reg[j+1]  <= seg_reg[j];
                klin_reg[j+1] <= klin_next;
                kpow_reg[j+1] <= kpow_next;
            end
        end
    end

    always_comb begin
        if (!pos_reg[CODE_W]) begin
            code = '0;
        end else if (seg_reg[CODE_W]) begin
            code = klin_reg[CODE_W];
        end else begin
            code = kpow_reg[CODE_W];
        end
    end

endmodule
`default_nettype wire

// ----- sv/l2s_merge.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// l2s_merge
// Joins the lane codes into one pixel beat, masks alpha when disabled and
// drives the output through an output register with a skid stage.
// ----------------------------------------------------------------------------
module l2s_merge (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            pipe_vld,
    input  wire l2s_pkg::codes_t                 codes,
    input  wire l2s_pkg::cfg_t                   cfg,
    output logic                                 adv,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [l2s_pkg::M_DATA_W-1:0]         m_tdata
);
    import l2s_pkg::*;

    codes_t pix;
    logic   take;

    logic   out_vld_reg,  out_vld_next;
    logic   skid_vld_reg, skid_vld_next;
    codes_t out_data_reg, out_data_next;
    codes_t skid_data_reg, skid_data_next;

    always_comb begin
        pix = codes;
        if (!cfg.alpha_enable) begin
            pix[ALPHA_LANE] = '0;
        end
    end

    assign adv  = !skid_vld_reg;
    assign take = pipe_vld && adv;

    always_comb begin
        out_vld_next   = out_vld_reg;
        skid_vld_next  = skid_vld_reg;
        out_data_next  = out_data_reg;
        skid_data_next = skid_data_reg;
        if (!out_vld_reg || m_tready) begin
            out_data_next = skid_vld_reg ? skid_data_reg : pix;
            out_vld_next  = skid_vld_reg || take;
            skid_vld_next = 1'b0;
        end else if (take) begin
            skid_data_next = pix;
            skid_vld_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule
`default_nettype wire

// ----- sv/l2s_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// l2s_regs
// APB register block holding the alpha enable control.
// ----------------------------------------------------------------------------
module l2s_regs (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [l2s_pkg::APB_AW-1:0]   paddr,
    input  wire logic [l2s_pkg::APB_DW-1:0]   pwdata,
    output logic [l2s_pkg::APB_DW-1:0]        prdata,
    output logic                              pready,
    output l2s_pkg::cfg_t                     cfg
);
    import l2s_pkg::*;

    logic alpha_en_reg, alpha_en_next;
    logic wr_en;
    logic hit;

    assign pready = 1'b1;
    assign hit    = paddr[APB_AW-1] == REG_ALPHA_ENABLE;
    assign wr_en  = psel && penable && pwrite && pready;

    always_comb begin
        alpha_en_next = alpha_en_reg;
        if (wr_en && hit) begin
            alpha_en_next = pwdata[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alpha_en_reg <= 1'b1;
        end else begin
            alpha_en_reg <= alpha_en_next;
        end
    end

    always_comb begin
        prdata = '0;
        if (hit) begin
            prdata[0] = alpha_en_reg;
        end
    end

    assign cfg.alpha_enable = alpha_en_reg;

endmodule
`default_nettype wire

// ----- sv/linear_to_srgb_pixel_encoder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_to_srgb_pixel_encoder_unit
// Encodes one linear RGBA pixel (four signed q3.16 channels) into four sRGB
// byte codes, one lane per channel.
//
//   channel  direction  ports          beat contents
//   s_       in         s_t*           red, green, blue, alpha linear, 20b each
//   m_       out        m_t*           red, green, blue, alpha codes, 8b each
//   apb      in/out     p*             alpha_enable at byte address 0
//
// one pixel beat per cycle sustained while m_tready stays high; from the
// accepting edge to m_tvalid the path runs through the capture register, which
// loads on the accepting edge, then 8 code bit stages and the output register.
// aresetn clears the valid line, output and skid flags; alpha_enable resets
// to 1.
// when m_tready is low the skid stage takes one more beat, then s_tready drops
// and the lane pipeline holds.
// ----------------------------------------------------------------------------
module linear_to_srgb_pixel_encoder_unit (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // red_lin, green_lin, blue_lin, alpha_lin
    input  wire logic [l2s_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // red_code, green_code, blue_code, alpha_code
    output logic [l2s_pkg::M_DATA_W-1:0]         m_tdata,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [l2s_pkg::APB_AW-1:0]      paddr,
    input  wire logic [l2s_pkg::APB_DW-1:0]      pwdata,
    output logic [l2s_pkg::APB_DW-1:0]           prdata,
    output logic                                 pready
);
    import l2s_pkg::*;

    cfg_t   cfg;
    codes_t codes;
    logic   adv;

    logic [CODE_W:0] vld_reg, vld_next;

    l2s_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        l2s_lane u_lane (
            .aclk   (aclk),
            .en     (adv),
            .lin_in (s_tdata[i*IN_W +: IN_W]),
            .code   (codes[i])
        );
    end

    assign s_tready = adv;

    always_comb begin
        vld_next = vld_reg;
        if (adv) begin
            vld_next = {vld_reg[CODE_W-1:0], s_tvalid};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    l2s_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .pipe_vld (vld_reg[CODE_W]),
        .codes    (codes),
        .cfg      (cfg),
        .adv      (adv),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Streams linear RGBA pixels into the sRGB encoder and checks every code beat
// against a bit-exact integer model of the transfer curve. alpha_enable is
// reprogrammed over the APB port between phases, and both stream sides stall
// at random rates.
// ----------------------------------------------------------------------------
module testbench;
    import l2s_pkg::*;

    class srgb_scoreboard;
        codes_t  expected_q[$];
        longint  curve_thr[TBL_N];
        bit      alpha_on;
        int      errors;
        string   lane_name[LANES] = '{"red", "green", "blue", "alpha"};

        function new();
            longint lq;
            alpha_on = 1'b1;
            errors = 0;
            lq = log2_q40(64'd53805);
            for (int k = 0; k < TBL_N; k++) begin
                curve_thr[k] = 64'sd50000 * (log2_q40(64'(200 * k + 2705)) - lq);
            end
        endfunction

        // log2 of an integer, 40 fraction bits, by squaring a q62 mantissa
        function longint log2_q40(longint unsigned x);
            logic [63:0]  mant;
            logic [63:0]  frac;
            logic [127:0] sq;
            int           e;
            if (x == 0) begin
                x = 1;
            end
            e = 0;
            while ((x >> (e + 1)) != 0 && e < 61) begin
                e++;
            end
            mant = x << (62 - e);
            frac = '0;
            repeat (LOG_FRAC) begin
                sq = {64'd0, mant} * {64'd0, mant};
                mant = sq[125:62];
                frac = frac << 1;
                if (mant[63]) begin
                    mant = mant >> 1;
                    frac[0] = 1'b1;
                end
            end
            return longint'((64'(e) << LOG_FRAC) | frac);
        endfunction

        function logic [CODE_W-1:0] encode_lane(logic [IN_W-1:0] raw);
            longint          n;
            longint unsigned u;
            longint unsigned c;
            longint          lv;
            int              lo;
            int              hi;
            int              mid;
            n = longint'($signed(raw));
            if (n <= 0) begin
                return '0;
            end
            u = n;
            if (u * 64'd10000000 < (64'd31308 << FRAC_BITS)) begin
                c = (64'd32946 * u + (64'd5 << FRAC_BITS)) / (64'd10 << FRAC_BITS);
                return (c > 255) ? 8'd255 : 8'(c);
            end
            lv = 64'sd20833 * (log2_q40(u) - (longint'(FRAC_BITS) <<< LOG_FRAC));
            lo = 0;
            hi = TBL_N - 1;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                if (lv >= curve_thr[mid]) begin
                    lo = mid;
                end else begin
                    hi = mid - 1;
                end
            end
            return 8'(lo);
        endfunction

        function void note_pixel(logic [S_DATA_W-1:0] beat);
            codes_t want;
            for (int l = 0; l < LANES; l++) begin
                want[l] = encode_lane(beat[l*IN_W +: IN_W]);
            end
            if (!alpha_on) begin
                want[ALPHA_LANE] = '0;
            end
            expected_q.push_back(want);
        endfunction

        function void flag(string what);
            errors++;
            if (errors <= 10) begin
                $display("%0t: %s", $time, what);
            end
        endfunction

        function void check_codes(logic [M_DATA_W-1:0] beat);
            codes_t got;
            codes_t want;
            got = beat;
            if (expected_q.size() == 0) begin
                flag($sformatf("unexpected code beat %h", beat));
                return;
            end
            want = expected_q.pop_front();
            for (int l = 0; l < LANES; l++) begin
                if (got[l] !== want[l]) begin
                    flag($sformatf("%s code: expected %0d, got %0d",
                                   lane_name[l], want[l], got[l]));
                end
            end
        endfunction
    endclass

    localparam int LIMIT_CYCLES  = 200000;
    localparam int DRAIN_CYCLES  = 20;
    localparam int ITEMS_PER_RUN = 367;
    localparam int DIR_N         = 18;
    localparam logic [APB_AW-1:0] ADDR_ALPHA_EN = APB_AW'(4 * REG_ALPHA_ENABLE);
    localparam logic [APB_AW-1:0] ADDR_UNMAPPED = APB_AW'(4);

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    // red_lin, green_lin, blue_lin, alpha_lin
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    // red_code, green_code, blue_code, alpha_code
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;

    int                    send_idle = 0;
    int                    recv_idle = 0;
    int                    cycles = 0;
    srgb_scoreboard        sb = new();

    logic [IN_W-1:0] dir_val [DIR_N] = '{
        20'd0, 20'd1, 20'hFFFFF, 20'h80000, 20'h7FFFF, 20'd205,
        20'd206, 20'd207, 20'd65535, 20'd65536, 20'd65537, 20'd32768,
        20'd16384, 20'd100, 20'd2000, 20'd8192, 20'd50000, 20'd60000
    };

    linear_to_srgb_pixel_encoder_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready = ($urandom_range(99) >= recv_idle);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                sb.note_pixel(s_tdata);
            end
            if (m_tvalid && m_tready) begin
                sb.check_codes(m_tdata);
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic logic [S_DATA_W-1:0] pack_pixel(logic [IN_W-1:0] r,
            logic [IN_W-1:0] g, logic [IN_W-1:0] b, logic [IN_W-1:0] a);
        return {a, b, g, r};
    endfunction

    function automatic logic [IN_W-1:0] rand_lin();
        case ($urandom_range(9))
            0: return IN_W'($urandom());
            1: return IN_W'($urandom_range(0, 300));
            2: return IN_W'(65536 + $urandom_range(0, 458751));
            3: return IN_W'(0 - $urandom_range(1, 524288));
            default: return IN_W'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic apb_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = addr;
        pwdata = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_ALPHA_EN) begin
            sb.alpha_on = data[0];
        end
        @(negedge aclk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic push_pixel(input logic [S_DATA_W-1:0] beat);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata = beat;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (sb.expected_q.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    initial begin
        int send_pct [3] = '{29, 72, 0};
        int recv_pct [3] = '{72, 29, 0};
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        apb_write(ADDR_ALPHA_EN, 32'h0000_0001);
        for (int i = 0; i < DIR_N; i++) begin
            push_pixel(pack_pixel(dir_val[i], dir_val[(i + 1) % DIR_N],
                                  dir_val[(i + 2) % DIR_N], dir_val[(i + 3) % DIR_N]));
        end
        wait_drained();

        // alpha off, upper bits of the write ignored
        apb_write(ADDR_ALPHA_EN, 32'hFFFF_FFFE);
        for (int i = 0; i < 4; i++) begin
            push_pixel(pack_pixel(dir_val[i + 8], dir_val[i + 4],
                                  dir_val[i], dir_val[i + 9]));
        end
        wait_drained();

        // write to an unmapped address leaves alpha off
        apb_write(ADDR_UNMAPPED, 32'h0000_0001);
        push_pixel(pack_pixel(20'd65536, 20'd30000, 20'd150, 20'd65536));
        push_pixel(pack_pixel(20'd1000, 20'h7FFFF, 20'h80000, 20'd40000));
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle = send_pct[ph];
            recv_idle = recv_pct[ph];
            apb_write(ADDR_ALPHA_EN, (ph == 1) ? 32'h0000_0000 : 32'h8000_0001);
            for (int i = 0; i < ITEMS_PER_RUN; i++) begin
                if (ph == 0 && i == ITEMS_PER_RUN / 2) begin
                    wait_drained();
                end
                push_pixel(pack_pixel(rand_lin(), rand_lin(), rand_lin(), rand_lin()));
            end
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
